FILE: hdl/vcgbm_pkg.sv
`timescale 1ns / 1ps
package vcgbm_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_RESTART = 2'd1,
    KIND_FIND    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] voxel_x;
    logic [3:0] voxel_y;
    logic [3:0] voxel_z;
    logic [7:0] material;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  box_x_start;
    logic [3:0]  box_y_start;
    logic [3:0]  box_z_start;
    logic [4:0]  box_x_end;
    logic [4:0]  box_y_end;
    logic [4:0]  box_z_end;
    logic [7:0]  box_material;
    logic [11:0] box_index;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_GROW_RD,
    ST_GROW_CHK,
    ST_MARK,
    ST_EMIT,
    ST_OUT
  } state_t;

  // growth phase while extending a box
  typedef enum logic [1:0] {
    PH_Z,
    PH_Y,
    PH_X
  } phase_t;

endpackage

FILE: hdl/voxel_chunk_greedy_box_merge.sv
`timescale 1ns / 1ps
// channel | ports                          | direction
// input   | in_valid, in_stall, in_data    | to block
// result  | out_valid, out_stall, out_data | from block
//
// Each cell is probed through the voxel and mark memories by a read state
// and a check state. A write is accepted in ST_IDLE and answered in ST_OUT;
// a find scans cells in ST_SCAN/ST_SCAN_CHK, probes cells while growing in
// ST_GROW_RD/ST_GROW_CHK and marks the box covered, then emits and answers.
// A restart sweeps all 2^(3*CW) mark memory addresses (EDGE^3 when EDGE is a
// power of two); the same sweep runs after reset and the voxel memory is
// cleared alongside it, while in_stall is high.
// out_data holds while out_stall is high; no input is taken until it leaves.
module voxel_chunk_greedy_box_merge #(
  parameter int EDGE = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  vcgbm_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output vcgbm_pkg::out_item_t out_data
);

  localparam int CW    = (EDGE > 1) ? $clog2(EDGE) : 1;
  localparam int EW    = $clog2(EDGE + 1);
  localparam int AW    = 3 * CW;
  // address space of {x, y, z}; addresses with y or z out of range stay empty
  localparam int SPACE = 1 << AW;
  localparam int XEND  = EDGE << (2 * CW);
  localparam int PW    = $clog2(SPACE + 1);

  logic [7:0] vox_mem [SPACE];
  logic       mark_mem [SPACE];

  vcgbm_pkg::state_t state_r, state_nxt;
  vcgbm_pkg::phase_t ph_r, ph_nxt;
  logic [PW-1:0] scan_r, scan_nxt;
  logic [11:0]   cnt_r, cnt_nxt;
  logic          clr_vox_r, clr_vox_nxt;
  // seed and box limits
  logic [CW-1:0] x0_r, y0_r, z0_r, x0_nxt, y0_nxt, z0_nxt;
  logic [EW-1:0] x1_r, y1_r, z1_r, x1_nxt, y1_nxt, z1_nxt;
  logic [7:0]    mat_r, mat_nxt;
  // probe cursor
  logic [CW-1:0] a_r, b_r, c_r, a_nxt, b_nxt, c_nxt;
  vcgbm_pkg::out_item_t res_r, res_nxt;

  // memory port signals
  logic          we_vox, we_mark, mark_val;
  logic [AW-1:0] wa_vox, wa_mark, ra;
  logic [7:0]    wd_vox, rd_vox_r;
  logic          rd_mark_r;
  logic          ok;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                              input logic [CW-1:0] y,
                                              input logic [CW-1:0] z);
    return {x, y, z};
  endfunction

  always_ff @(posedge clk) begin
    if (we_vox) vox_mem[wa_vox] <= wd_vox;
    if (we_mark) mark_mem[wa_mark] <= mark_val;
    rd_vox_r  <= vox_mem[ra];
    rd_mark_r <= mark_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= vcgbm_pkg::ST_CLEAR;
      clr_vox_r <= 1'b1;
      scan_r    <= '0;
      cnt_r     <= '0;
      ph_r      <= vcgbm_pkg::PH_Z;
    end else begin
      state_r   <= state_nxt;
      clr_vox_r <= clr_vox_nxt;
      scan_r    <= scan_nxt;
      cnt_r     <= cnt_nxt;
      ph_r      <= ph_nxt;
    end
    x0_r <= x0_nxt; y0_r <= y0_nxt; z0_r <= z0_nxt;
    x1_r <= x1_nxt; y1_r <= y1_nxt; z1_r <= z1_nxt;
    a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt;
    mat_r <= mat_nxt;
    res_r <= res_nxt;
  end

  assign in_stall  = (state_r != vcgbm_pkg::ST_IDLE);
  assign out_valid = (state_r == vcgbm_pkg::ST_OUT);
  assign out_data  = res_r;
  assign ok        = (rd_vox_r == mat_r) && !rd_mark_r;

  always_comb begin
    state_nxt = state_r; ph_nxt = ph_r;
    scan_nxt = scan_r; cnt_nxt = cnt_r; clr_vox_nxt = clr_vox_r;
    x0_nxt = x0_r; y0_nxt = y0_r; z0_nxt = z0_r;
    x1_nxt = x1_r; y1_nxt = y1_r; z1_nxt = z1_r;
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r;
    mat_nxt = mat_r; res_nxt = res_r;
    we_vox = 1'b0; wa_vox = scan_r[AW-1:0]; wd_vox = '0;
    we_mark = 1'b0; wa_mark = scan_r[AW-1:0]; mark_val = 1'b0;
    ra = scan_r[AW-1:0];
    case (state_r)
      vcgbm_pkg::ST_IDLE: begin
        if (in_valid) begin
          res_nxt = '0;
          state_nxt = vcgbm_pkg::ST_OUT;
          case (in_data.kind)
            vcgbm_pkg::KIND_WRITE: begin
              if (32'(in_data.voxel_x) < EDGE && 32'(in_data.voxel_y) < EDGE &&
                  32'(in_data.voxel_z) < EDGE) begin
                we_vox = 1'b1;
                wa_vox = cell_addr(CW'(in_data.voxel_x), CW'(in_data.voxel_y),
                                   CW'(in_data.voxel_z));
                wd_vox = in_data.material;
              end
            end
            vcgbm_pkg::KIND_RESTART: begin
              scan_nxt = '0;
              cnt_nxt = '0;
              state_nxt = vcgbm_pkg::ST_CLEAR;
            end
            vcgbm_pkg::KIND_FIND: begin
              state_nxt = vcgbm_pkg::ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      // sweep marks (and voxels after reset), scan_r is the sweep address
      vcgbm_pkg::ST_CLEAR: begin
        we_mark = 1'b1;
        we_vox = clr_vox_r;
        if (scan_r == PW'(SPACE - 1)) begin
          scan_nxt = '0;
          clr_vox_nxt = 1'b0;
          state_nxt = clr_vox_r ? vcgbm_pkg::ST_IDLE : vcgbm_pkg::ST_OUT;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      // issue read at scan position
      vcgbm_pkg::ST_SCAN: begin
        if (scan_r >= PW'(XEND)) state_nxt = vcgbm_pkg::ST_OUT;
        else state_nxt = vcgbm_pkg::ST_SCAN_CHK;
      end
      vcgbm_pkg::ST_SCAN_CHK: begin
        if (rd_vox_r == 8'd0 || rd_mark_r) begin
          scan_nxt = scan_r + 1'b1;
          state_nxt = vcgbm_pkg::ST_SCAN;
        end else begin
          {x0_nxt, y0_nxt, z0_nxt} = scan_r[AW-1:0];
          mat_nxt = rd_vox_r;
          x1_nxt = EW'(x0_nxt) + 1'b1;
          y1_nxt = EW'(y0_nxt) + 1'b1;
          z1_nxt = EW'(z0_nxt) + 1'b1;
          ph_nxt = vcgbm_pkg::PH_Z;
          a_nxt = x0_nxt; b_nxt = y0_nxt; c_nxt = CW'(z1_nxt);
          state_nxt = vcgbm_pkg::ST_GROW_RD;
          if (z1_nxt == EW'(EDGE)) begin
            ph_nxt = vcgbm_pkg::PH_Y;
            b_nxt = CW'(y1_nxt); c_nxt = z0_nxt;
            if (y1_nxt == EW'(EDGE)) begin
              ph_nxt = vcgbm_pkg::PH_X;
              a_nxt = CW'(x1_nxt); b_nxt = y0_nxt;
              if (x1_nxt == EW'(EDGE)) begin
                a_nxt = x0_nxt;
                state_nxt = vcgbm_pkg::ST_MARK;
              end
            end
          end
        end
      end
      vcgbm_pkg::ST_GROW_RD: begin
        ra = cell_addr(a_r, b_r, c_r);
        state_nxt = vcgbm_pkg::ST_GROW_CHK;
      end
      // one probe result: advance cursor or close the current axis
      vcgbm_pkg::ST_GROW_CHK: begin
        state_nxt = vcgbm_pkg::ST_GROW_RD;
        case (ph_r)
          vcgbm_pkg::PH_Z: begin
            if (ok) begin
              z1_nxt = z1_r + 1'b1;
              c_nxt = c_r + 1'b1;
            end
            if (!ok || z1_nxt == EW'(EDGE)) begin
              ph_nxt = vcgbm_pkg::PH_Y;
              b_nxt = CW'(y1_r); c_nxt = z0_r;
              if (y1_r == EW'(EDGE)) begin
                ph_nxt = vcgbm_pkg::PH_X;
                a_nxt = CW'(x1_r); b_nxt = y0_r;
                if (x1_r == EW'(EDGE)) begin
                  a_nxt = x0_r; state_nxt = vcgbm_pkg::ST_MARK;
                end
              end
            end
          end
          vcgbm_pkg::PH_Y: begin
            if (ok && EW'(c_r) + 1'b1 != z1_r) begin
              c_nxt = c_r + 1'b1;
            end else begin
              if (ok) y1_nxt = y1_r + 1'b1;
              b_nxt = CW'(y1_nxt); c_nxt = z0_r;
              if (!ok || y1_nxt == EW'(EDGE)) begin
                ph_nxt = vcgbm_pkg::PH_X;
                a_nxt = CW'(x1_r); b_nxt = y0_r;
                if (x1_r == EW'(EDGE)) begin
                  a_nxt = x0_r; state_nxt = vcgbm_pkg::ST_MARK;
                end
              end
            end
          end
          default: begin
            if (ok && EW'(c_r) + 1'b1 != z1_r) begin
              c_nxt = c_r + 1'b1;
            end else if (ok && EW'(b_r) + 1'b1 != y1_r) begin
              b_nxt = b_r + 1'b1; c_nxt = z0_r;
            end else begin
              if (ok) x1_nxt = x1_r + 1'b1;
              a_nxt = CW'(x1_nxt); b_nxt = y0_r; c_nxt = z0_r;
              if (!ok || x1_nxt == EW'(EDGE)) begin
                a_nxt = x0_r; state_nxt = vcgbm_pkg::ST_MARK;
              end
            end
          end
        endcase
      end
      // mark the box covered one cell a cycle
      vcgbm_pkg::ST_MARK: begin
        we_mark = 1'b1; mark_val = 1'b1;
        wa_mark = cell_addr(a_r, b_r, c_r);
        if (EW'(c_r) + 1'b1 != z1_r) begin
          c_nxt = c_r + 1'b1;
        end else if (EW'(b_r) + 1'b1 != y1_r) begin
          b_nxt = b_r + 1'b1; c_nxt = z0_r;
        end else if (EW'(a_r) + 1'b1 != x1_r) begin
          a_nxt = a_r + 1'b1; b_nxt = y0_r; c_nxt = z0_r;
        end else begin
          state_nxt = vcgbm_pkg::ST_EMIT;
        end
      end
      vcgbm_pkg::ST_EMIT: begin
        res_nxt.found = 1'b1;
        res_nxt.box_x_start = 4'(x0_r);
        res_nxt.box_y_start = 4'(y0_r);
        res_nxt.box_z_start = 4'(z0_r);
        res_nxt.box_x_end = 5'(x1_r);
        res_nxt.box_y_end = 5'(y1_r);
        res_nxt.box_z_end = 5'(z1_r);
        res_nxt.box_material = mat_r;
        res_nxt.box_index = cnt_r;
        cnt_nxt = cnt_r + 1'b1;
        scan_nxt = scan_r + 1'b1;
        state_nxt = vcgbm_pkg::ST_OUT;
      end
      vcgbm_pkg::ST_OUT: begin
        if (!out_stall) state_nxt = vcgbm_pkg::ST_IDLE;
      end
      default: state_nxt = vcgbm_pkg::ST_IDLE;
    endcase
  end

endmodule
